// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion shorthands, reset-qualified on rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TCT_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define TCT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/tct_pkg.sv =====
// ----------------------------------------------------------------------------
// tct_pkg
// Widths, request and result types, and tangent codes for the common
// tangents core.
// ----------------------------------------------------------------------------
`default_nettype none

package tct_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int RW          = COORD_WIDTH - 1;
  localparam int DW          = COORD_WIDTH + 1;
  localparam int D2W         = 2 * DW;
  localparam int HW          = COORD_WIDTH + 1;
  localparam int UF          = 125 - 2 * COORD_WIDTH;
  localparam int QW          = UF + 1;
  localparam int MCH         = 26;
  localparam int NCH         = (QW + MCH - 1) / MCH;
  localparam int OMW         = RW + 2;
  localparam int TW          = 2;

  typedef logic [TW-1:0] tan_idx_t;

  localparam tan_idx_t TAN_OUTER_PLUS  = tan_idx_t'(0);
  localparam tan_idx_t TAN_OUTER_MINUS = tan_idx_t'(1);
  localparam tan_idx_t TAN_INNER_PLUS  = tan_idx_t'(2);
  localparam tan_idx_t TAN_INNER_MINUS = tan_idx_t'(3);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] center_a_x;
    logic signed [COORD_WIDTH-1:0] center_a_y;
    logic        [RW-1:0]          radius_a;
    logic signed [COORD_WIDTH-1:0] center_b_x;
    logic signed [COORD_WIDTH-1:0] center_b_y;
    logic        [RW-1:0]          radius_b;
  } req_t;

  typedef struct packed {
    tan_idx_t                      tangent_index;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic                          exists;
    logic                          last;
  } rsp_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic        [RW-1:0]          ra;
    logic        [RW-1:0]          rb;
    tan_idx_t                      idx;
  } geo_t;

  typedef struct packed {
    geo_t                  geo;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic signed [DW-1:0]  k;
    logic        [D2W-1:0] d2;
    logic                  ok;
  } sq_side_t;

  typedef struct packed {
    geo_t geo;
    logic ok;
    logic neg_x;
    logic neg_y;
  } div_side_t;

  function automatic logic is_outer(input tan_idx_t t);
    return (t == TAN_OUTER_PLUS) || (t == TAN_OUTER_MINUS);
  endfunction

  function automatic logic is_plus(input tan_idx_t t);
    return (t == TAN_OUTER_PLUS) || (t == TAN_INNER_PLUS);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tct_sqrt.sv =====
// ----------------------------------------------------------------------------
// tct_sqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_sqrt
  import tct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [D2W-1:0]   rad_i,
  input  sq_side_t         side_i,
  output logic             valid_o,
  output logic [HW-1:0]    root_o,
  output sq_side_t         side_o
);

  localparam int TRW = D2W + 2;

  logic           vld_q  [HW];
  logic [D2W-1:0] rem_q  [HW];
  logic [HW-1:0]  root_q [HW];
  sq_side_t       side_q [HW];

  for (genvar i = 0; i < HW; i++) begin : g_stage
    localparam int B = HW - 1 - i;

    logic           vld_in;
    logic [D2W-1:0] rem_in;
    logic [HW-1:0]  root_in;
    sq_side_t       side_in;
    logic [TRW-1:0] trial;
    logic           take;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign side_in = side_q[i-1];
    end

    assign trial = ({{(TRW-HW){1'b0}}, root_in} << (B + 1)) + (TRW'(1) << (2 * B));
    assign take  = {2'b00, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= take ? (rem_in - trial[D2W-1:0]) : rem_in;
      root_q[i] <= take ? (root_in | (HW'(1) << B)) : root_in;
      side_q[i] <= side_in;
    end
  end

  assign valid_o = vld_q[HW-1];
  assign root_o  = root_q[HW-1];
  assign side_o  = side_q[HW-1];

endmodule

`default_nettype wire

// ===== hdl/tct_div.sv =====
// ----------------------------------------------------------------------------
// tct_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_div
  import tct_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [D2W-1:0]        den_i,
  input  logic [1:0][D2W-1:0]   num_i,
  input  div_side_t             side_i,
  output logic                  valid_o,
  output logic [1:0][QW-1:0]    quo_o,
  output div_side_t             side_o
);

  logic                vld_q  [QW];
  logic [D2W-1:0]      den_q  [QW];
  logic [1:0][D2W-1:0] rem_q  [QW];
  logic [1:0][QW-1:0]  quo_q  [QW];
  div_side_t           side_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic                vld_in;
    logic [D2W-1:0]      den_in;
    logic [1:0][D2W-1:0] rem_in;
    logic [1:0][QW-1:0]  quo_in;
    div_side_t           side_in;
    logic [1:0][D2W:0]   part;
    logic [1:0]          take;
    logic [1:0][D2W-1:0] rem_d;
    logic [1:0][QW-1:0]  quo_d;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign den_in  = den_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign part[l] = {1'b0, rem_in[l]};
      end
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign den_in  = den_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign side_in = side_q[i-1];
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign part[l] = {rem_in[l], 1'b0};
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_step
      logic [D2W:0] diff;
      assign diff     = part[l] - {1'b0, den_in};
      assign take[l]  = part[l] >= {1'b0, den_in};
      assign rem_d[l] = take[l] ? diff[D2W-1:0] : part[l][D2W-1:0];
      assign quo_d[l] = {quo_in[l][QW-2:0], take[l]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[i]  <= den_in;
      rem_q[i]  <= rem_d;
      quo_q[i]  <= quo_d;
      side_q[i] <= side_in;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

`default_nettype wire

// ===== hdl/tct_place.sv =====
// ----------------------------------------------------------------------------
// tct_place
// Scale the unit direction by each radius, round, offset the centres and
// saturate the touch points; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tct_place
  import tct_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [1:0][QW-1:0] quo_i,
  input  div_side_t          side_i,
  output logic               valid_o,
  output rsp_t               rsp_o
);

  localparam int QEW   = NCH * MCH;
  localparam int PPW   = RW + MCH;
  localparam int SW    = RW + QEW + 1;
  localparam int OFW   = OMW + 1;
  localparam int PW    = OFW + 1;
  localparam int LANES = 4;

  function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic [PW-1:0] v);
    priority if (v[PW-1:COORD_WIDTH-1] == {(PW-COORD_WIDTH+1){v[PW-1]}}) begin
      return v[COORD_WIDTH-1:0];
    end else if (v[PW-1]) begin
      return {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

  logic [RW-1:0]  lane_rad [LANES];
  logic [QEW-1:0] lane_q   [LANES];
  logic [PPW-1:0] pp_d     [LANES][NCH];
  logic [PPW-1:0] pp_q     [LANES][NCH];
  logic           p1_vld_q;
  div_side_t      p1_side_q;

  always_comb begin
    lane_rad[0] = side_i.geo.ra;
    lane_rad[1] = side_i.geo.ra;
    lane_rad[2] = side_i.geo.rb;
    lane_rad[3] = side_i.geo.rb;
    lane_q[0]   = QEW'(quo_i[0]);
    lane_q[1]   = QEW'(quo_i[1]);
    lane_q[2]   = QEW'(quo_i[0]);
    lane_q[3]   = QEW'(quo_i[1]);
    for (int l = 0; l < LANES; l++) begin
      for (int j = 0; j < NCH; j++) begin
        pp_d[l][j] = PPW'(lane_rad[l]) * PPW'(lane_q[l][j*MCH +: MCH]);
      end
    end
  end

  logic                  inner;
  logic                  lane_neg [LANES];
  logic [SW-1:0]         acc;
  logic [OMW-1:0]        mag;
  logic signed [OFW-1:0] off_d    [LANES];
  logic signed [OFW-1:0] off_q    [LANES];
  logic                  p2_vld_q;
  div_side_t             p2_side_q;

  always_comb begin
    inner       = !is_outer(p1_side_q.geo.idx);
    lane_neg[0] = p1_side_q.neg_x;
    lane_neg[1] = p1_side_q.neg_y;
    lane_neg[2] = p1_side_q.neg_x ^ inner;
    lane_neg[3] = p1_side_q.neg_y ^ inner;
    acc = '0;
    mag = '0;
    for (int l = 0; l < LANES; l++) begin
      acc = SW'(1) << (UF - 1);
      for (int j = 0; j < NCH; j++) begin
        acc = acc + (SW'(pp_q[l][j]) << (j * MCH));
      end
      mag = acc[UF +: OMW];
      off_d[l] = (lane_neg[l] && (mag != '0)) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  logic signed [COORD_WIDTH-1:0] lane_ctr [LANES];
  logic signed [PW-1:0]          pt       [LANES];
  logic [COORD_WIDTH-1:0]        pt_sat   [LANES];
  rsp_t                          rsp_d;
  rsp_t                          rsp_q;
  logic                          rsp_vld_q;

  always_comb begin
    lane_ctr[0] = p2_side_q.geo.ax;
    lane_ctr[1] = p2_side_q.geo.ay;
    lane_ctr[2] = p2_side_q.geo.bx;
    lane_ctr[3] = p2_side_q.geo.by;
    for (int l = 0; l < LANES; l++) begin
      pt[l]     = PW'(lane_ctr[l]) + PW'(off_q[l]);
      pt_sat[l] = p2_side_q.ok ? sat_coord(pt[l]) : '0;
    end
    rsp_d.tangent_index = p2_side_q.geo.idx;
    rsp_d.start_x       = pt_sat[0];
    rsp_d.start_y       = pt_sat[1];
    rsp_d.end_x         = pt_sat[2];
    rsp_d.end_y         = pt_sat[3];
    rsp_d.exists        = p2_side_q.ok;
    rsp_d.last          = p2_side_q.geo.idx == TAN_INNER_MINUS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      p1_vld_q  <= valid_i;
      p2_vld_q  <= p1_vld_q;
      rsp_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_q      <= pp_d;
    p1_side_q <= side_i;
    off_q     <= off_d;
    p2_side_q <= p1_side_q;
    rsp_q     <= rsp_d;
  end

  assign valid_o = rsp_vld_q;
  assign rsp_o   = rsp_q;

endmodule

`default_nettype wire

// ===== hdl/two_circle_common_tangents_core.sv =====
// ----------------------------------------------------------------------------
// two_circle_common_tangents_core
// Path: sequencer, stages 1-3, tct_sqrt, stages 4-5, tct_div, tct_place;
//   the first result is followed by the other three on consecutive cycles.
// Throughput: one result per cycle; busy is high while the first three
//   tangents of a request are issued, so the next request is taken while
//   the fourth is issued. Results cannot be stalled.
// Reset: rst_ni clears all valid bits and the sequencer; no results pending.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module two_circle_common_tangents_core
  import tct_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int PHW = DW + HW + 1;
  localparam int NXW = PHW + 1;

  // Request sequencer: issue the four tangents of one request
  req_t     req_q;
  logic     act_q, act_d;
  tan_idx_t cnt_q, cnt_d;
  logic     accept;

  assign busy   = act_q && (cnt_q != TAN_INNER_MINUS);
  assign accept = start && !busy;

  always_comb begin
    act_d = act_q;
    cnt_d = cnt_q;
    priority if (accept) begin
      act_d = 1'b1;
      cnt_d = TAN_OUTER_PLUS;
    end else if (act_q) begin
      if (cnt_q == TAN_INNER_MINUS) begin
        act_d = 1'b0;
      end
      cnt_d = cnt_q + tan_idx_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  geo_t                 iss_geo;
  logic signed [DW-1:0] iss_dx, iss_dy, iss_ra, iss_rb, iss_k;

  always_comb begin
    iss_geo.ax  = req_q.center_a_x;
    iss_geo.ay  = req_q.center_a_y;
    iss_geo.bx  = req_q.center_b_x;
    iss_geo.by  = req_q.center_b_y;
    iss_geo.ra  = req_q.radius_a;
    iss_geo.rb  = req_q.radius_b;
    iss_geo.idx = cnt_q;
    iss_dx = DW'($signed(req_q.center_b_x)) - DW'($signed(req_q.center_a_x));
    iss_dy = DW'($signed(req_q.center_b_y)) - DW'($signed(req_q.center_a_y));
    iss_ra = $signed(DW'(req_q.radius_a));
    iss_rb = $signed(DW'(req_q.radius_b));
    iss_k  = is_outer(cnt_q) ? (iss_ra - iss_rb) : (iss_ra + iss_rb);
  end

  // Stage 1: differences
  logic                 s1_vld_q;
  geo_t                 s1_geo_q;
  logic signed [DW-1:0] s1_dx_q, s1_dy_q, s1_k_q;

  // Stage 2: squares
  logic                  s2_vld_q;
  geo_t                  s2_geo_q;
  logic signed [DW-1:0]  s2_dx_q, s2_dy_q, s2_k_q;
  logic signed [D2W-1:0] s2_dxx_q, s2_dyy_q, s2_kk_q;

  // Stage 3: distance squared and radicand
  logic           s3_vld_q;
  logic [D2W-1:0] s3_rad_q;
  sq_side_t       s3_side_q;
  logic [D2W-1:0] s2_d2;

  assign s2_d2 = s2_dxx_q + s2_dyy_q;

  always_ff @(posedge clk_i) begin
    s1_geo_q <= iss_geo;
    s1_dx_q  <= iss_dx;
    s1_dy_q  <= iss_dy;
    s1_k_q   <= iss_k;

    s2_geo_q <= s1_geo_q;
    s2_dx_q  <= s1_dx_q;
    s2_dy_q  <= s1_dy_q;
    s2_k_q   <= s1_k_q;
    s2_dxx_q <= s1_dx_q * s1_dx_q;
    s2_dyy_q <= s1_dy_q * s1_dy_q;
    s2_kk_q  <= s1_k_q * s1_k_q;

    s3_rad_q       <= s2_d2 - s2_kk_q;
    s3_side_q.geo  <= s2_geo_q;
    s3_side_q.dx   <= s2_dx_q;
    s3_side_q.dy   <= s2_dy_q;
    s3_side_q.k    <= s2_k_q;
    s3_side_q.d2   <= s2_d2;
    s3_side_q.ok   <= (s2_d2 != '0) && (s2_d2 >= s2_kk_q);
  end

  logic          sq_vld;
  logic [HW-1:0] sq_root;
  sq_side_t      sq_side;

  tct_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_vld_q),
    .rad_i   (s3_rad_q),
    .side_i  (s3_side_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Stage 4: numerator products
  logic signed [HW:0]    sq_h;
  logic                  s4_vld_q;
  geo_t                  s4_geo_q;
  logic [D2W-1:0]        s4_d2_q;
  logic                  s4_ok_q;
  logic signed [D2W-1:0] s4_pxk_q, s4_pyk_q;
  logic signed [PHW-1:0] s4_pyh_q, s4_pxh_q;

  assign sq_h = $signed({1'b0, sq_root});

  always_ff @(posedge clk_i) begin
    s4_geo_q <= sq_side.geo;
    s4_d2_q  <= sq_side.d2;
    s4_ok_q  <= sq_side.ok;
    s4_pxk_q <= $signed(sq_side.dx) * $signed(sq_side.k);
    s4_pyk_q <= $signed(sq_side.dy) * $signed(sq_side.k);
    s4_pyh_q <= $signed(sq_side.dy) * sq_h;
    s4_pxh_q <= $signed(sq_side.dx) * sq_h;
  end

  // Stage 5: numerators, sign and magnitude
  logic signed [NXW-1:0] nx, ny, pxk_e, pyk_e, pyh_e, pxh_e;
  logic                  s5_vld_q;
  logic [D2W-1:0]        s5_den_q;
  logic [1:0][D2W-1:0]   s5_num_q;
  div_side_t             s5_side_q;

  always_comb begin
    pxk_e = NXW'(s4_pxk_q);
    pyk_e = NXW'(s4_pyk_q);
    pyh_e = NXW'(s4_pyh_q);
    pxh_e = NXW'(s4_pxh_q);
    if (is_plus(s4_geo_q.idx)) begin
      nx = pxk_e - pyh_e;
      ny = pyk_e + pxh_e;
    end else begin
      nx = pxk_e + pyh_e;
      ny = pyk_e - pxh_e;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_den_q        <= s4_d2_q;
    s5_num_q[0]     <= nx[NXW-1] ? D2W'(-nx) : D2W'(nx);
    s5_num_q[1]     <= ny[NXW-1] ? D2W'(-ny) : D2W'(ny);
    s5_side_q.geo   <= s4_geo_q;
    s5_side_q.ok    <= s4_ok_q;
    s5_side_q.neg_x <= nx[NXW-1];
    s5_side_q.neg_y <= ny[NXW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      cnt_q    <= TAN_OUTER_PLUS;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      act_q    <= act_d;
      cnt_q    <= cnt_d;
      s1_vld_q <= act_q;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= sq_vld;
      s5_vld_q <= s4_vld_q;
    end
  end

  logic               dv_vld;
  logic [1:0][QW-1:0] dv_quo;
  div_side_t          dv_side;

  tct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s5_vld_q),
    .den_i   (s5_den_q),
    .num_i   (s5_num_q),
    .side_i  (s5_side_q),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  tct_place u_place (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_vld),
    .quo_i   (dv_quo),
    .side_i  (dv_side),
    .valid_o (rsp_valid_o),
    .rsp_o   (rsp_o)
  );

  `TCT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request taken without raising busy")
  `TCT_ASSERT_CLK(a_burst, rsp_valid_o && (rsp_o.tangent_index != TAN_OUTER_PLUS) |-> $past(rsp_valid_o), "result burst broken")
  `TCT_ASSERT_CLK(a_burst_start, rsp_valid_o && (rsp_o.tangent_index == TAN_OUTER_PLUS) |-> !$past(rsp_valid_o) || $past(rsp_o.last), "result burst started early")
  `TCT_ASSERT_CLK(a_zero_points, rsp_valid_o && !rsp_o.exists |-> (rsp_o.start_x == '0) && (rsp_o.start_y == '0) && (rsp_o.end_x == '0) && (rsp_o.end_y == '0), "missing tangent with nonzero points")

endmodule

`default_nettype wire
